// ===== rtl/nbsht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbsht_pkg
// Shared constants and controller/datapath command types for the nearest bus
// segment hit test.
// ----------------------------------------------------------------------------
package nbsht_pkg;

  localparam int COORD_BITS_DEF  = 24;
  localparam int NET_ID_BITS_DEF = 16;
  localparam int RADIUS_BITS     = 26;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 32;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(100);

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_QUERY_X    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_QUERY_Y    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HIT_RADIUS = 2'd2;

  // multiplier operations; the product is registered with its tag (prod, prod_tag) and then folded into its target
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_NX,   // (qx - ax) * abx  -> num
    MUL_NY,   // (qy - ay) * aby  -> num +=
    MUL_DX,   // abx * abx        -> den
    MUL_DY,   // aby * aby        -> den +=
    MUL_XH,   // num_hi * |abx|   -> rem_x
    MUL_XL,   // num_lo * |abx|   -> rem_x += , low bits
    MUL_YH,
    MUL_YL,
    MUL_SX,   // dx * dx          -> d2
    MUL_SY    // dy * dy          -> d2 +=
  } mul_op_t;

  typedef struct packed {
    logic    load;
    mul_op_t mul;
    logic    pick_a;
    logic    pick_b;
    logic    pick_p;
    logic    div_step;
    logic    sqrt_init;
    logic    sqrt_step;
    logic    update;
    logic    emit;
  } nbsht_cmd_t;

  typedef struct packed {
    logic skip;
    logic num_le0;
    logic num_ge_den;
  } nbsht_status_t;

endpackage

// ===== rtl/nbsht_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbsht_dpath
// Datapath: config registers, shared multiplier, two radix-2 dividers,
// bit-pair square root, running best and output register.
// ----------------------------------------------------------------------------
module nbsht_dpath #(
  parameter int COORD_BITS  = nbsht_pkg::COORD_BITS_DEF,
  parameter int NET_ID_BITS = nbsht_pkg::NET_ID_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [nbsht_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [nbsht_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  nbsht_pkg::nbsht_cmd_t                cmd,
  output nbsht_pkg::nbsht_status_t             status,
  input  logic                                 first_segment,
  input  logic [COORD_BITS-1:0]                start_x,
  input  logic [COORD_BITS-1:0]                start_y,
  input  logic [COORD_BITS-1:0]                end_x,
  input  logic [COORD_BITS-1:0]                end_y,
  input  logic                                 is_bus,
  input  logic [NET_ID_BITS-1:0]               net_id,
  output logic                                 found,
  output logic [COORD_BITS-1:0]                hit_x,
  output logic [COORD_BITS-1:0]                hit_y,
  output logic [NET_ID_BITS-1:0]               hit_net,
  output logic [nbsht_pkg::RADIUS_BITS-1:0]    hit_dist
);
  import nbsht_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int W  = C + 1;
  localparam int MW = W + 1;
  localparam int PW = 2 * MW;
  localparam int RW = 2 * W + 1;
  localparam int SW = W + 4;
  localparam int DW = (W > RADIUS_BITS) ? W : RADIUS_BITS;

  // truncation toward zero of a + num*d/den given q = floor(num*|d|/den)
  function automatic logic [C-1:0] proj_axis(input logic [C-1:0] a, input logic neg,
                                             input logic [W-1:0] q, input logic frac);
    logic signed [W:0] ae;
    logic signed [W:0] qs;
    logic signed [W:0] fl;
    logic signed [W:0] res;
    ae = $signed({{2{a[C-1]}}, a});
    qs = $signed({1'b0, q});
    if (!neg) begin
      fl  = ae + qs;
      res = (frac && fl[W]) ? fl + (W+1)'(1) : fl;
    end else if (!frac) begin
      res = ae - qs;
    end else begin
      fl  = ae - qs - (W+1)'(1);
      res = fl[W] ? fl + (W+1)'(1) : fl;
    end
    return res[C-1:0];
  endfunction

  logic [C-1:0]           qx, qy;
  logic [RADIUS_BITS-1:0] radius;
  logic [C-1:0]           ax, ay, bx, by;
  logic [NET_ID_BITS-1:0] net;
  logic                   skip;

  logic signed [W-1:0]  abx, aby, qdx, qdy, dx, dy;
  logic [W-1:0]         magx, magy;
  logic signed [MW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod;
  mul_op_t              prod_tag;
  logic signed [PW-1:0] num, den;
  logic [RW-1:0]        den_u;

  logic [RW-1:0] rem_x, rem_y, tx, ty;
  logic [W-1:0]  lx, ly, quo_x, quo_y;
  logic          ge_x, ge_y;
  logic [C-1:0]  cx, cy;

  logic [2*W-1:0] d2, rad;
  logic [W+1:0]   srem;
  logic [W-1:0]   root;
  logic [SW-1:0]  st, strial, sdiff;
  logic           sge;

  logic [RADIUS_BITS-1:0] best_dist;
  logic [C-1:0]           best_x, best_y;
  logic [NET_ID_BITS-1:0] best_net;
  logic                   any_hit;
  logic [DW-1:0]          dist_ext, best_ext;

  assign abx  = $signed({bx[C-1], bx}) - $signed({ax[C-1], ax});
  assign aby  = $signed({by[C-1], by}) - $signed({ay[C-1], ay});
  assign qdx  = $signed({qx[C-1], qx}) - $signed({ax[C-1], ax});
  assign qdy  = $signed({qy[C-1], qy}) - $signed({ay[C-1], ay});
  assign dx   = $signed({cx[C-1], cx}) - $signed({qx[C-1], qx});
  assign dy   = $signed({cy[C-1], cy}) - $signed({qy[C-1], qy});
  assign magx = abx[W-1] ? W'(-abx) : abx;
  assign magy = aby[W-1] ? W'(-aby) : aby;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul)
      MUL_NX: begin op_a = {qdx[W-1], qdx}; op_b = {abx[W-1], abx}; end
      MUL_NY: begin op_a = {qdy[W-1], qdy}; op_b = {aby[W-1], aby}; end
      MUL_DX: begin op_a = {abx[W-1], abx}; op_b = {abx[W-1], abx}; end
      MUL_DY: begin op_a = {aby[W-1], aby}; op_b = {aby[W-1], aby}; end
      MUL_XH: begin op_a = {1'b0, num[2*W-1:W]}; op_b = {1'b0, magx}; end
      MUL_XL: begin op_a = {1'b0, num[W-1:0]};   op_b = {1'b0, magx}; end
      MUL_YH: begin op_a = {1'b0, num[2*W-1:W]}; op_b = {1'b0, magy}; end
      MUL_YL: begin op_a = {1'b0, num[W-1:0]};   op_b = {1'b0, magy}; end
      MUL_SX: begin op_a = {dx[W-1], dx}; op_b = {dx[W-1], dx}; end
      MUL_SY: begin op_a = {dy[W-1], dy}; op_b = {dy[W-1], dy}; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign den_u = den[RW-1:0];
  assign tx    = {rem_x[RW-2:0], lx[W-1]};
  assign ty    = {rem_y[RW-2:0], ly[W-1]};
  assign ge_x  = tx >= den_u;
  assign ge_y  = ty >= den_u;

  assign st     = {srem, rad[2*W-1 -: 2]};
  assign strial = {2'b00, root, 2'b01};
  assign sge    = st >= strial;
  assign sdiff  = st - strial;

  assign dist_ext = DW'(root);
  assign best_ext = DW'(best_dist);

  assign status.skip       = skip;
  assign status.num_le0    = num[PW-1] || (num == '0);
  assign status.num_ge_den = num >= den;

  // config registers and running best
  always_ff @(posedge clk) begin
    if (rst) begin
      qx        <= '0;
      qy        <= '0;
      radius    <= RADIUS_RESET;
      best_dist <= RADIUS_RESET;
      best_x    <= '0;
      best_y    <= '0;
      best_net  <= '0;
      any_hit   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUERY_X:    qx     <= cfg_data[C-1:0];
          CFG_QUERY_Y:    qy     <= cfg_data[C-1:0];
          CFG_HIT_RADIUS: radius <= cfg_data[RADIUS_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.load && first_segment) begin
        best_dist <= radius;
        best_x    <= '0;
        best_y    <= '0;
        best_net  <= '0;
        any_hit   <= 1'b0;
      end else if (cmd.update && (dist_ext < best_ext)) begin
        best_dist <= RADIUS_BITS'(root);
        best_x    <= cx;
        best_y    <= cy;
        best_net  <= net;
        any_hit   <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax   <= start_x;
      ay   <= start_y;
      bx   <= end_x;
      by   <= end_y;
      net  <= net_id;
      skip <= !is_bus || ((start_x == end_x) && (start_y == end_y));
    end
    prod     <= op_a * op_b;
    prod_tag <= cmd.mul;
    case (prod_tag)
      MUL_NX: num <= prod;
      MUL_NY: num <= num + prod;
      MUL_DX: den <= prod;
      MUL_DY: den <= den + prod;
      MUL_XH: rem_x <= prod[RW-1:0];
      MUL_XL: begin
        rem_x <= rem_x + RW'(prod[2*W-1:W]);
        lx    <= prod[W-1:0];
      end
      MUL_YH: rem_y <= prod[RW-1:0];
      MUL_YL: begin
        rem_y <= rem_y + RW'(prod[2*W-1:W]);
        ly    <= prod[W-1:0];
      end
      MUL_SX: d2 <= prod[2*W-1:0];
      MUL_SY: d2 <= d2 + prod[2*W-1:0];
      default: ;
    endcase
    if (cmd.div_step) begin
      rem_x <= ge_x ? tx - den_u : tx;
      rem_y <= ge_y ? ty - den_u : ty;
      quo_x <= {quo_x[W-2:0], ge_x};
      quo_y <= {quo_y[W-2:0], ge_y};
      lx    <= {lx[W-2:0], 1'b0};
      ly    <= {ly[W-2:0], 1'b0};
    end
    if (cmd.pick_a) begin
      cx <= ax;
      cy <= ay;
    end else if (cmd.pick_b) begin
      cx <= bx;
      cy <= by;
    end else if (cmd.pick_p) begin
      cx <= proj_axis(ax, abx[W-1], quo_x, |rem_x);
      cy <= proj_axis(ay, aby[W-1], quo_y, |rem_y);
    end
    if (cmd.sqrt_init) begin
      rad  <= d2;
      srem <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      rad  <= {rad[2*W-3:0], 2'b00};
      srem <= sge ? sdiff[W+1:0] : st[W+1:0];
      root <= {root[W-2:0], sge};
    end
    if (cmd.emit) begin
      found    <= any_hit;
      hit_x    <= best_x;
      hit_y    <= best_y;
      hit_net  <= best_net;
      hit_dist <= best_dist;
    end
  end

endmodule

// ===== rtl/nbsht_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbsht_ctrl
// Sequencer: steps one segment through products, division, square root and
// compare, and owns the output valid.
// ----------------------------------------------------------------------------
module nbsht_ctrl #(
  parameter int COORD_BITS = nbsht_pkg::COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output nbsht_pkg::nbsht_cmd_t    cmd,
  input  nbsht_pkg::nbsht_status_t status
);
  import nbsht_pkg::*;

  localparam int W  = COORD_BITS + 1;
  localparam int CW = $clog2(W);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_NX, ST_NY, ST_DX, ST_DY, ST_WAIT_DEN, ST_DECIDE,
    ST_XH, ST_XL, ST_YH, ST_YL, ST_WAIT_REM, ST_DIV, ST_PICK, ST_SX, ST_SY,
    ST_WAIT_D2, ST_ROOT_INIT, ST_ROOT, ST_UPDATE, ST_EMIT
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          cnt_last;

  assign in_ready = (state == ST_IDLE);
  assign cnt_last = (cnt == CW'(W - 1));

  always_comb begin
    cmd           = '0;
    cmd.mul       = MUL_NONE;
    cmd.load      = in_valid && (state == ST_IDLE);
    cmd.pick_a    = (state == ST_DECIDE) && status.num_le0;
    cmd.pick_b    = (state == ST_DECIDE) && !status.num_le0 && status.num_ge_den;
    cmd.pick_p    = (state == ST_PICK);
    cmd.div_step  = (state == ST_DIV);
    cmd.sqrt_init = (state == ST_ROOT_INIT);
    cmd.sqrt_step = (state == ST_ROOT);
    cmd.update    = (state == ST_UPDATE);
    cmd.emit      = (state == ST_EMIT) && (!out_valid || out_ready);
    case (state)
      ST_NX:   cmd.mul = MUL_NX;
      ST_NY:   cmd.mul = MUL_NY;
      ST_DX:   cmd.mul = MUL_DX;
      ST_DY:   cmd.mul = MUL_DY;
      ST_XH:   cmd.mul = MUL_XH;
      ST_XL:   cmd.mul = MUL_XL;
      ST_YH:   cmd.mul = MUL_YH;
      ST_YL:   cmd.mul = MUL_YL;
      ST_SX:   cmd.mul = MUL_SX;
      ST_SY:   cmd.mul = MUL_SY;
      default: cmd.mul = MUL_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE:      if (in_valid) state <= ST_CHECK;
        ST_CHECK:     state <= status.skip ? ST_EMIT : ST_NX;
        ST_NX:        state <= ST_NY;
        ST_NY:        state <= ST_DX;
        ST_DX:        state <= ST_DY;
        ST_DY:        state <= ST_WAIT_DEN;
        ST_WAIT_DEN:  state <= ST_DECIDE;
        ST_DECIDE: begin
          if (status.num_le0 || status.num_ge_den) begin
            state <= ST_SX;
          end else begin
            state <= ST_XH;
          end
        end
        ST_XH:        state <= ST_XL;
        ST_XL:        state <= ST_YH;
        ST_YH:        state <= ST_YL;
        ST_YL:        state <= ST_WAIT_REM;
        ST_WAIT_REM: begin
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt + CW'(1);
          if (cnt_last) state <= ST_PICK;
        end
        ST_PICK:      state <= ST_SX;
        ST_SX:        state <= ST_SY;
        ST_SY:        state <= ST_WAIT_D2;
        ST_WAIT_D2:   state <= ST_ROOT_INIT;
        ST_ROOT_INIT: begin
          cnt   <= '0;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          cnt <= cnt + CW'(1);
          if (cnt_last) state <= ST_UPDATE;
        end
        ST_UPDATE:    state <= ST_EMIT;
        ST_EMIT:      if (cmd.emit) state <= ST_IDLE;
        default:      state <= ST_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a segment is in progress");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("output register overwritten before it was taken");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("output valid raised without an emit");

  a_pick_once: assert property (@(posedge clk) disable iff (rst)
    !(cmd.pick_a && cmd.pick_b))
    else $error("both end points picked");

endmodule

// ===== rtl/nearest_bus_segment_hit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_bus_segment_hit_test
// Streams line segments past a configured query point and keeps the nearest
// bus segment hit closer than the configured radius.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (0 qx, 1 qy, 2 radius)
//  in      | in_valid / in_ready    | first_segment, start/end x,y, is_bus, net_id
//  out     | out_valid / out_ready  | found, hit_x, hit_y, hit_net, hit_dist
//
//  One item at a time. A skipped segment (not bus, or zero length) goes
//  from its check straight to its emit; a segment clamped to an end point
//  skips the division, and a projected one runs it before the square root.
//  The two radix-2 dividers run side by side and the square root gives
//  one result bit a cycle. One 26x26 multiplier is shared by all products.
//  After each emit the sequencer returns to idle, where it takes the next
//  item; a stalled result only holds the sequencer at its emit step.
//  cfg_ready is always high. Reset is synchronous: radius and best
//  distance go to 100, query point and best hit to zero.
// ----------------------------------------------------------------------------
module nearest_bus_segment_hit_test #(
  parameter int COORD_BITS  = nbsht_pkg::COORD_BITS_DEF,
  parameter int NET_ID_BITS = nbsht_pkg::NET_ID_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nbsht_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [nbsht_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 first_segment,
  input  logic [COORD_BITS-1:0]                start_x,
  input  logic [COORD_BITS-1:0]                start_y,
  input  logic [COORD_BITS-1:0]                end_x,
  input  logic [COORD_BITS-1:0]                end_y,
  input  logic                                 is_bus,
  input  logic [NET_ID_BITS-1:0]               net_id,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 found,
  output logic [COORD_BITS-1:0]                hit_x,
  output logic [COORD_BITS-1:0]                hit_y,
  output logic [NET_ID_BITS-1:0]               hit_net,
  output logic [nbsht_pkg::RADIUS_BITS-1:0]    hit_dist
);
  import nbsht_pkg::*;

  nbsht_cmd_t    cmd;
  nbsht_status_t status;

  // the user must issue config writes only while idle (not enforced here); with cfg_ready high they are always taken
  assign cfg_ready = 1'b1;

  nbsht_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  nbsht_dpath #(
    .COORD_BITS  (COORD_BITS),
    .NET_ID_BITS (NET_ID_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .status        (status),
    .first_segment (first_segment),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .is_bus        (is_bus),
    .net_id        (net_id),
    .found         (found),
    .hit_x         (hit_x),
    .hit_y         (hit_y),
    .hit_net       (hit_net),
    .hit_dist      (hit_dist)
  );

endmodule
